// ----- src/ypt_pkg.sv -----
`default_nettype none

package ypt_pkg;

    // value and angle formats
    localparam int VALUE_WIDTH   = 24;
    localparam int ANGLE_WIDTH   = 16;
    localparam int CORDIC_STAGES = 16;

    // cordic works on a 32-bit turn angle, c and s in q4.30
    localparam int TURN_WIDTH   = 32;
    localparam int CORDIC_WIDTH = 34;
    localparam int PROD_FRAC    = 30;
    localparam logic signed [CORDIC_WIDTH-1:0] GAIN_Q30 = 34'sd652032874;

    // truncated arctangent table, units of 2^-32 turn
    localparam logic [TURN_WIDTH-1:0] ATAN_TURN [32] = '{
        32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335086,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41721,     32'd20860,
        32'd10430,     32'd5215,      32'd2607,      32'd1303,
        32'd651,       32'd325,       32'd162,       32'd81,
        32'd40,        32'd20,        32'd10,        32'd5,
        32'd2,         32'd1,         32'd0,         32'd0
    };

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // start to done: front reg, queue, cordic stages, flip, multiply, round
    localparam int LATENCY = CORDIC_STAGES + 6;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;

    typedef struct packed {
        logic signed [CORDIC_WIDTH-1:0] angle;
        logic                           flip;
        value_t                         vx;
        value_t                         vy;
        value_t                         vz;
        logic [1:0]                     tag;
        logic                           clip;
    } item_t;

    typedef struct packed {
        value_t value;
        logic   clip;
    } sat_t;

    // saturating add of two values
    function automatic sat_t sat_add(input value_t a, input value_t b);
        logic signed [VALUE_WIDTH:0] sum;
        sat_t                        res;
        sum = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
        if (sum[VALUE_WIDTH] != sum[VALUE_WIDTH-1])
        begin
            res.value = {sum[VALUE_WIDTH], {(VALUE_WIDTH-1){~sum[VALUE_WIDTH]}}};
            res.clip  = 1'b1;
        end
        else
        begin
            res.value = sum[VALUE_WIDTH-1:0];
            res.clip  = 1'b0;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- src/ypt_front.sv -----
`default_nettype none

module ypt_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              full,
    input  logic [ypt_pkg::ANGLE_WIDTH-1:0]   yaw_angle,
    input  ypt_pkg::value_t                   first_x,
    input  ypt_pkg::value_t                   first_y,
    input  ypt_pkg::value_t                   first_z,
    input  ypt_pkg::value_t                   second_x,
    input  ypt_pkg::value_t                   second_y,
    input  ypt_pkg::value_t                   second_z,
    input  logic [1:0]                        slot_tag,
    output logic                              push,
    output ypt_pkg::item_t                    item
);
    import ypt_pkg::*;

    logic                  accept;
    logic                  valid_reg;
    logic                  valid_next;
    item_t                 item_reg;
    item_t                 item_next;
    logic [TURN_WIDTH-1:0] turn;
    sat_t                  sum_x;
    sat_t                  sum_y;
    sat_t                  sum_z;

    assign accept = start & ~full;

    always_comb
    begin
        // left-align the angle, fold quadrants 1 and 2 by half a turn
        turn           = TURN_WIDTH'(yaw_angle) << (TURN_WIDTH - ANGLE_WIDTH);
        item_next.flip = turn[TURN_WIDTH-1] ^ turn[TURN_WIDTH-2];
        turn[TURN_WIDTH-1] = turn[TURN_WIDTH-1] ^ item_next.flip;
        item_next.angle = {{(CORDIC_WIDTH-TURN_WIDTH){turn[TURN_WIDTH-1]}}, turn};

        sum_x = sat_add(first_x, second_x);
        sum_y = sat_add(first_y, second_y);
        sum_z = sat_add(first_z, second_z);
        item_next.vx   = sum_x.value;
        item_next.vy   = sum_y.value;
        item_next.vz   = sum_z.value;
        item_next.tag  = slot_tag;
        item_next.clip = sum_x.clip | sum_y.clip | sum_z.clip;

        valid_next = accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    assign push = valid_reg;
    assign item = item_reg;

endmodule

`default_nettype wire

// ----- src/ypt_queue.sv -----
`default_nettype none

module ypt_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ypt_pkg::item_t  wr_item,
    output logic            rd_valid,
    output ypt_pkg::item_t  rd_item,
    output logic            full
);
    import ypt_pkg::*;

    item_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_next;
    logic [QUEUE_AW:0]    count_reg;
    logic [QUEUE_AW:0]    count_next;
    logic                 pop;

    // the back end never stalls, so the head leaves whenever there is one
    assign pop      = count_reg != '0;
    assign rd_valid = pop;
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign full     = count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

// ----- src/ypt_back.sv -----
`default_nettype none

module ypt_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  ypt_pkg::item_t  in_item,
    output logic            done,
    output ypt_pkg::value_t result_x,
    output ypt_pkg::value_t result_y,
    output ypt_pkg::value_t result_z,
    output logic [1:0]      result_tag,
    output logic            clipped
);
    import ypt_pkg::*;

    localparam int PW = CORDIC_WIDTH + VALUE_WIDTH;
    localparam int SW = PW + 1;
    localparam logic signed [SW-1:0] ROUND = SW'(1) <<< (PROD_FRAC - 1);
    localparam logic signed [SW-1:0] VMAX  =
        {{(SW-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] VMIN  = ~VMAX;

    // cordic pipeline
    logic                           vld_reg [CORDIC_STAGES+1];
    logic signed [CORDIC_WIDTH-1:0] x_reg   [CORDIC_STAGES+1];
    logic signed [CORDIC_WIDTH-1:0] y_reg   [CORDIC_STAGES+1];
    logic signed [CORDIC_WIDTH-1:0] z_reg   [CORDIC_STAGES+1];
    item_t                          it_reg  [CORDIC_STAGES+1];

    // flip, multiply and round stages
    logic                           f_vld_reg;
    logic signed [CORDIC_WIDTH-1:0] c_reg;
    logic signed [CORDIC_WIDTH-1:0] s_reg;
    item_t                          f_it_reg;
    logic                           m_vld_reg;
    logic signed [PW-1:0]           pxx_reg;
    logic signed [PW-1:0]           pxy_reg;
    logic signed [PW-1:0]           pyx_reg;
    logic signed [PW-1:0]           pyy_reg;
    item_t                          m_it_reg;

    logic                           done_reg;
    value_t                         rx_reg;
    value_t                         rx_next;
    value_t                         ry_reg;
    value_t                         ry_next;
    value_t                         rz_reg;
    logic [1:0]                     tag_reg;
    logic                           clip_reg;
    logic                           clip_next;
    logic signed [SW-1:0]           sum_x;
    logic signed [SW-1:0]           sum_y;
    logic signed [SW-1:0]           sh_x;
    logic signed [SW-1:0]           sh_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]  <= GAIN_Q30;
        y_reg[0]  <= '0;
        z_reg[0]  <= in_item.angle;
        it_reg[0] <= in_item;
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        logic signed [CORDIC_WIDTH-1:0] dx;
        logic signed [CORDIC_WIDTH-1:0] dy;
        logic signed [CORDIC_WIDTH-1:0] at;
        logic signed [CORDIC_WIDTH-1:0] x_next;
        logic signed [CORDIC_WIDTH-1:0] y_next;
        logic signed [CORDIC_WIDTH-1:0] z_next;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        assign at = $signed({{(CORDIC_WIDTH-TURN_WIDTH){1'b0}}, ATAN_TURN[i]});

        always_comb
        begin
            if (!z_reg[i][CORDIC_WIDTH-1])
            begin
                x_next = x_reg[i] - dx;
                y_next = y_reg[i] + dy;
                z_next = z_reg[i] - at;
            end
            else
            begin
                x_next = x_reg[i] + dx;
                y_next = y_reg[i] - dy;
                z_next = z_reg[i] + at;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[i+1]  <= x_next;
            y_reg[i+1]  <= y_next;
            z_reg[i+1]  <= z_next;
            it_reg[i+1] <= it_reg[i];
        end
    end

    // rounded dot products, half up, then saturate
    always_comb
    begin
        sum_x = SW'(pxx_reg) + SW'(pxy_reg) + ROUND;
        sum_y = SW'(pyy_reg) - SW'(pyx_reg) + ROUND;
        sh_x  = sum_x >>> PROD_FRAC;
        sh_y  = sum_y >>> PROD_FRAC;
        clip_next = m_it_reg.clip;
        if (sh_x > VMAX)
        begin
            rx_next   = VMAX[VALUE_WIDTH-1:0];
            clip_next = 1'b1;
        end
        else if (sh_x < VMIN)
        begin
            rx_next   = VMIN[VALUE_WIDTH-1:0];
            clip_next = 1'b1;
        end
        else
        begin
            rx_next = sh_x[VALUE_WIDTH-1:0];
        end
        if (sh_y > VMAX)
        begin
            ry_next   = VMAX[VALUE_WIDTH-1:0];
            clip_next = 1'b1;
        end
        else if (sh_y < VMIN)
        begin
            ry_next   = VMIN[VALUE_WIDTH-1:0];
            clip_next = 1'b1;
        end
        else
        begin
            ry_next = sh_y[VALUE_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            f_vld_reg <= vld_reg[CORDIC_STAGES];
            m_vld_reg <= f_vld_reg;
            done_reg  <= m_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // undo the half-turn fold
        c_reg    <= it_reg[CORDIC_STAGES].flip ? -x_reg[CORDIC_STAGES] : x_reg[CORDIC_STAGES];
        s_reg    <= it_reg[CORDIC_STAGES].flip ? -y_reg[CORDIC_STAGES] : y_reg[CORDIC_STAGES];
        f_it_reg <= it_reg[CORDIC_STAGES];

        pxx_reg  <= c_reg * $signed(f_it_reg.vx);
        pxy_reg  <= s_reg * $signed(f_it_reg.vy);
        pyx_reg  <= s_reg * $signed(f_it_reg.vx);
        pyy_reg  <= c_reg * $signed(f_it_reg.vy);
        m_it_reg <= f_it_reg;

        rx_reg   <= rx_next;
        ry_reg   <= ry_next;
        rz_reg   <= m_it_reg.vz;
        tag_reg  <= m_it_reg.tag;
        clip_reg <= clip_next;
    end

    assign done       = done_reg;
    assign result_x   = rx_reg;
    assign result_y   = ry_reg;
    assign result_z   = rz_reg;
    assign result_tag = tag_reg;
    assign clipped    = clip_reg;

endmodule

`default_nettype wire

// ----- src/yaw_pose_transform.sv -----
`default_nettype none

// yaw pose transform: each word carries a yaw angle (binary angle, a full turn
// is 2^16) and two signed q8.16 3-vectors. the vectors are added with
// saturation, the sum's x,y are turned by minus the yaw (x' = c.x + s.y,
// y' = -s.x + c.y) and z passes through. a camera pose is four words: the
// position, then the three orientation rows with the second vector at zero.
// a word is taken when start is high and busy is low; one result word per
// input word leaves on done, exactly one cycle wide, in order. a new word
// may be given every cycle: the front registers the sums and folds the
// angle, a two-word queue hands it to the back, which runs a 16-stage unrolled
// cordic, a sign-fix stage, a multiply stage and a round-and-saturate stage.
// the back never stalls and the receiver cannot stall it, so the queue drains
// every cycle and busy stays low in steady operation. clipped flags any
// saturated sum or rotated product. result_tag echoes slot_tag.

module yaw_pose_transform (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ypt_pkg::ANGLE_WIDTH-1:0]   yaw_angle,
    input  ypt_pkg::value_t                   first_x,
    input  ypt_pkg::value_t                   first_y,
    input  ypt_pkg::value_t                   first_z,
    input  ypt_pkg::value_t                   second_x,
    input  ypt_pkg::value_t                   second_y,
    input  ypt_pkg::value_t                   second_z,
    input  logic [1:0]                        slot_tag,
    output logic                              done,
    output ypt_pkg::value_t                   result_x,
    output ypt_pkg::value_t                   result_y,
    output ypt_pkg::value_t                   result_z,
    output logic [1:0]                        result_tag,
    output logic                              clipped
);
    import ypt_pkg::*;

    // front to queue
    logic  push;
    item_t fr_item;

    // queue to back
    logic  q_valid;
    item_t q_item;
    logic  q_full;

    ypt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .full      (q_full),
        .yaw_angle (yaw_angle),
        .first_x   (first_x),
        .first_y   (first_y),
        .first_z   (first_z),
        .second_x  (second_x),
        .second_y  (second_y),
        .second_z  (second_z),
        .slot_tag  (slot_tag),
        .push      (push),
        .item      (fr_item)
    );

    ypt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_item  (fr_item),
        .rd_valid (q_valid),
        .rd_item  (q_item),
        .full     (q_full)
    );

    ypt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .in_item    (q_item),
        .done       (done),
        .result_x   (result_x),
        .result_y   (result_y),
        .result_z   (result_z),
        .result_tag (result_tag),
        .clipped    (clipped)
    );

    // a full queue holds off new words
    assign busy = q_full;

endmodule

`default_nettype wire

// ----- src/ypt_checker.sv -----
`default_nettype none

module ypt_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [ypt_pkg::ANGLE_WIDTH-1:0]   yaw_angle,
    input  ypt_pkg::value_t                   first_x,
    input  ypt_pkg::value_t                   first_y,
    input  ypt_pkg::value_t                   first_z,
    input  ypt_pkg::value_t                   second_x,
    input  ypt_pkg::value_t                   second_y,
    input  ypt_pkg::value_t                   second_z,
    input  logic [1:0]                        slot_tag,
    input  logic                              done,
    input  ypt_pkg::value_t                   result_x,
    input  ypt_pkg::value_t                   result_y,
    input  ypt_pkg::value_t                   result_z,
    input  logic [1:0]                        result_tag,
    input  logic                              clipped
);
    import ypt_pkg::*;

    logic accept;
    logic zero_in;

    assign accept  = start & ~busy;
    assign zero_in = (first_x == '0) && (first_y == '0) && (first_z == '0) &&
                     (second_x == '0) && (second_y == '0) && (second_z == '0);

    // every accepted word comes out a fixed time later
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted word did not produce a result");

    // no result without a word behind it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without an accepted word");

    // tag travels with its word
    a_tag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result_tag == $past(slot_tag, LATENCY))
        else $error("result tag does not match its word");

    // zero vectors give a zero result at any yaw
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(zero_in, LATENCY) |->
            (result_x == '0) && (result_y == '0) && (result_z == '0) && !clipped)
        else $error("zero input gave a non-zero result");

endmodule

bind yaw_pose_transform ypt_checker u_ypt_checker (.*);

`default_nettype wire
